// ===== sv/i2c_master_byte_engine_defines.svh =====
// ---------------------------------------------------------------------------
// I2C master byte engine assertion macros
// ---------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_ENGINE_DEFINES_SVH
`define I2C_MASTER_BYTE_ENGINE_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define I2CM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked while out of reset
`define I2CM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/i2cm_pkg.sv =====
// ---------------------------------------------------------------------------
// i2cm_pkg
// Types and constants shared by the I2C master byte engine files.
// ---------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

  // bus phases of the byte sequencer
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SA,     // start: both lines high
    ST_SB,     // start: SDA falls
    ST_SC,     // start: SCL falls
    ST_PA,     // stop: both low
    ST_PB,     // stop: SCL rises
    ST_PC,     // stop: SDA rises
    ST_WA,     // write: set data bit
    ST_WB,     // write: SCL high
    ST_WC,     // write: SCL low
    ST_KA,     // ack: release SDA
    ST_KB,     // ack: SCL high
    ST_KPOLL,  // ack: poll SDA
    ST_KC,     // ack: SCL low
    ST_RA,     // read: SCL low, SDA released
    ST_RB,     // read: SCL high, sample on last tick
    ST_NA,     // read: drive ACK/NACK
    ST_NB      // read: SCL high for ACK/NACK
  } step_t;

  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_READ  = 3'd4;

  localparam logic REG_HALF_PERIOD = 1'b0;
  localparam logic REG_ACK_TIMEOUT = 1'b1;

  localparam logic [7:0]  HALF_PERIOD_RST = 8'd5;
  localparam logic [15:0] ACK_TIMEOUT_RST = 16'd250;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_DATA_W = 16;

endpackage

`default_nettype wire

// ===== sv/i2c_master_byte_engine.sv =====
// ---------------------------------------------------------------------------
// i2c_master_byte_engine
// I2C master sequencer for start, stop, byte write and byte read.
// ---------------------------------------------------------------------------
// Usage:
//   Each input beat is one timebase tick. It carries a command (only taken
//   while idle), the byte to send, the ACK choice for reads and the sampled
//   SDA level. Every input beat produces exactly one output beat with the
//   SCL/SDA line controls, busy/done flags, last received byte and status.
//   The result of a tick appears on out_* in the cycle after its input beat
//   is accepted. Throughput: one tick per cycle when not stalled; the
//   sequencer state and result register update together in a single pass.
//   Backpressure: an input beat is taken when no result is held or it is
//   taken in the same cycle; if the receiver stalls, in_tready drops and the
//   engine state freezes, so bus timing counts only accepted ticks.
//   Reset (rst_n low, synchronous): idle, SCL high, SDA driven high,
//   half_period 5, ack_timeout 250, no result pending.
//   Configuration writes (cfg_we) take effect at once; do them while idle.
//   A write that gets no ACK within ack_timeout polls sends a stop and
//   reports status 1.
// ---------------------------------------------------------------------------
`default_nettype none

module i2c_master_byte_engine
  import i2cm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // cmd[2:0], tx_byte[10:3], send_ack[11], sda_in[12], zero[15:13]
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // scl_level[0], sda_drive[1], sda_level[2], busy_res[3], done_res[4],
  // rx_byte[12:5], status[13], zero[15:14]
  output logic [OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                  cfg_we,
  input  wire logic [0:0]            cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [7:0]  half_period_r;
  logic [15:0] ack_timeout_r;

  step_t       step_r, step_nxt;
  logic [7:0]  delay_r, delay_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [15:0] wait_r, wait_nxt;
  logic        scl_r, scl_nxt;
  logic        drive_r, drive_nxt;
  logic        level_r, level_nxt;
  logic        ack_r, ack_nxt;
  logic        status_r, status_nxt;
  logic [7:0]  rx_r, rx_nxt;
  logic        done_nxt;
  logic        enter;     // a phase is entered this tick
  logic        scl_drop;  // end of read: release clock low

  logic        out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [2:0]  cmd;
  logic [7:0]  tx_byte;
  logic        send_ack;
  logic        sda_in;
  logic [7:0]  reload;
  logic        accept;

  assign cmd      = in_tdata[2:0];
  assign tx_byte  = in_tdata[10:3];
  assign send_ack = in_tdata[11];
  assign sda_in   = in_tdata[12];
  assign reload   = (half_period_r == 8'd0) ? 8'd1 : half_period_r;

  assign in_tready  = !out_valid_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_period_r <= HALF_PERIOD_RST;
      ack_timeout_r <= ACK_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_HALF_PERIOD: half_period_r <= cfg_wdata[7:0];
        REG_ACK_TIMEOUT: ack_timeout_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // sequencing and datapath
  always_comb begin
    step_nxt   = step_r;
    delay_nxt  = delay_r;
    bit_nxt    = bit_r;
    shift_nxt  = shift_r;
    wait_nxt   = wait_r;
    ack_nxt    = ack_r;
    status_nxt = status_r;
    rx_nxt     = rx_r;
    done_nxt   = 1'b0;
    enter      = 1'b0;
    scl_drop   = 1'b0;

    if (step_r == ST_IDLE) begin
      if (cmd == CMD_START || cmd == CMD_STOP || cmd == CMD_WRITE || cmd == CMD_READ) begin
        status_nxt = 1'b0;
        bit_nxt    = 3'd0;
        enter      = 1'b1;
        case (cmd)
          CMD_START: step_nxt = ST_SA;
          CMD_STOP:  step_nxt = ST_PA;
          CMD_WRITE: begin
            shift_nxt = tx_byte;
            step_nxt  = ST_WA;
          end
          default: begin
            shift_nxt = 8'd0;
            ack_nxt   = send_ack;
            step_nxt  = ST_RA;
          end
        endcase
      end
    end else if (step_r == ST_KPOLL) begin
      if (!sda_in) begin
        step_nxt = ST_KC;
        enter    = 1'b1;
      end else if (wait_r >= ack_timeout_r) begin
        status_nxt = 1'b1;
        step_nxt   = ST_PA;
        enter      = 1'b1;
      end else begin
        wait_nxt = wait_r + 16'd1;
      end
    end else if (delay_r > 8'd1) begin
      delay_nxt = delay_r - 8'd1;
    end else begin
      enter = 1'b1;
      case (step_r)
        ST_SA: step_nxt = ST_SB;
        ST_SB: step_nxt = ST_SC;
        ST_PA: step_nxt = ST_PB;
        ST_PB: step_nxt = ST_PC;
        ST_WA: step_nxt = ST_WB;
        ST_WB: step_nxt = ST_WC;
        ST_WC: begin
          if (bit_r == 3'd7) begin
            step_nxt = ST_KA;
          end else begin
            bit_nxt   = bit_r + 3'd1;
            shift_nxt = {shift_r[6:0], 1'b0};
            step_nxt  = ST_WA;
          end
        end
        ST_KA: step_nxt = ST_KB;
        ST_KB: step_nxt = ST_KPOLL;
        ST_RA: step_nxt = ST_RB;
        ST_RB: begin
          shift_nxt = {shift_r[6:0], sda_in};
          if (bit_r == 3'd7) begin
            step_nxt = ST_NA;
          end else begin
            bit_nxt  = bit_r + 3'd1;
            step_nxt = ST_RA;
          end
        end
        ST_NA: step_nxt = ST_NB;
        ST_NB: begin
          scl_drop = 1'b1;
          rx_nxt   = shift_r;
          enter    = 1'b0;
          step_nxt = ST_IDLE;
          delay_nxt = 8'd0;
          done_nxt = 1'b1;
        end
        default: begin
          // last phase of start, stop and ack
          enter     = 1'b0;
          step_nxt  = ST_IDLE;
          delay_nxt = 8'd0;
          done_nxt  = 1'b1;
        end
      endcase
    end

    if (enter) begin
      delay_nxt = reload;
      if (step_nxt == ST_KPOLL) begin
        wait_nxt = 16'd0;
      end
    end
  end

  // line levels set on phase entry and when a read ends
  always_comb begin
    scl_nxt   = scl_r;
    drive_nxt = drive_r;
    level_nxt = level_r;
    if (scl_drop) begin
      scl_nxt = 1'b0;
    end
    if (enter) begin
      case (step_nxt)
        ST_SA: begin
          drive_nxt = 1'b1;
          level_nxt = 1'b1;
          scl_nxt   = 1'b1;
        end
        ST_SB: level_nxt = 1'b0;
        ST_SC: scl_nxt = 1'b0;
        ST_PA: begin
          drive_nxt = 1'b1;
          scl_nxt   = 1'b0;
          level_nxt = 1'b0;
        end
        ST_PB: scl_nxt = 1'b1;
        ST_PC: level_nxt = 1'b1;
        ST_WA: begin
          drive_nxt = 1'b1;
          scl_nxt   = 1'b0;
          level_nxt = shift_nxt[7];
        end
        ST_WB: scl_nxt = 1'b1;
        ST_WC: scl_nxt = 1'b0;
        ST_KA: drive_nxt = 1'b0;
        ST_KB: scl_nxt = 1'b1;
        ST_KC: scl_nxt = 1'b0;
        ST_RA: begin
          drive_nxt = 1'b0;
          scl_nxt   = 1'b0;
        end
        ST_RB: scl_nxt = 1'b1;
        ST_NA: begin
          scl_nxt   = 1'b0;
          drive_nxt = 1'b1;
          level_nxt = !ack_nxt;
        end
        ST_NB: scl_nxt = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r   <= ST_IDLE;
      delay_r  <= 8'd0;
      bit_r    <= 3'd0;
      shift_r  <= 8'd0;
      wait_r   <= 16'd0;
      scl_r    <= 1'b1;
      drive_r  <= 1'b1;
      level_r  <= 1'b1;
      ack_r    <= 1'b0;
      status_r <= 1'b0;
      rx_r     <= 8'd0;
    end else if (accept) begin
      step_r   <= step_nxt;
      delay_r  <= delay_nxt;
      bit_r    <= bit_nxt;
      shift_r  <= shift_nxt;
      wait_r   <= wait_nxt;
      scl_r    <= scl_nxt;
      drive_r  <= drive_nxt;
      level_r  <= level_nxt;
      ack_r    <= ack_nxt;
      status_r <= status_nxt;
      rx_r     <= rx_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= {2'b00, status_nxt, rx_nxt, done_nxt, (step_nxt != ST_IDLE),
                     level_nxt, drive_nxt, scl_nxt};
    end
  end

endmodule

`default_nettype wire

// ===== sv/i2cm_checker.sv =====
// ---------------------------------------------------------------------------
// i2cm_checker
// Port-level checks for the I2C master byte engine, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "i2c_master_byte_engine_defines.svh"

module i2cm_port_checker
  import i2cm_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata
);

  // a stalled result beat holds
  `I2CM_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result beat changed while stalled")

  // every accepted tick yields a result beat next cycle
  `I2CM_ASSERT_NEXT(a_in_to_out, in_tvalid && in_tready, out_tvalid, "tick without result")

  // no backpressure while the result register is empty
  `I2CM_ASSERT_IMPL(a_ready_empty, !out_tvalid, in_tready, "input stalled with empty result register")

  // done pulses only on the tick that returns to idle
  `I2CM_ASSERT_IMPL(a_done_idle, out_tvalid && out_tdata[4], !out_tdata[3], "done while busy")

endmodule

bind i2c_master_byte_engine i2cm_port_checker u_i2cm_port_checker (.*);

`default_nettype wire
